### hw/rtl/rcp_pkg.sv
`timescale 1ns / 1ps

package rcp_pkg;

    localparam int RING_SIZE = 64;
    localparam int NODE_W    = $clog2(RING_SIZE);
    localparam int CNT_W     = 6;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_REPLICA_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_PRIMARY_COUNT = 2'd1;

    localparam logic [63:0] RING_ALL = {64{1'b1}};

    typedef struct packed {
        logic [CNT_W-1:0] replica_count;
        logic [CNT_W-1:0] primary_count;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS_INIT,
        S_ROUND,
        S_RD,
        S_MASK,
        S_CMP,
        S_PICK,
        S_PASS_END,
        S_OSCAN,
        S_ODATA,
        S_OWAIT
    } state_t;

    // Key spaces served by a node: the r positions just below it on the ring.
    function automatic logic [63:0] node_span(logic [NODE_W-1:0] node,
                                              logic [CNT_W-1:0] r);
        logic [63:0]       low;
        logic [127:0]      dbl;
        logic [NODE_W-1:0] sh;
        low = (64'd1 << r) - 64'd1;
        sh  = node - r;
        dbl = {low, low} << sh;
        return dbl[127:64];
    endfunction

    function automatic logic [6:0] pop_count(logic [63:0] x);
        logic [6:0] n;
        n = 7'd0;
        for (int k = 0; k < 64; k++) begin
            n = n + {6'd0, x[k]};
        end
        return n;
    endfunction

endpackage

### hw/rtl/rcp_ram.sv
`timescale 1ns / 1ps

module rcp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/rcp_engine.sv
`timescale 1ns / 1ps

module rcp_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rcp_pkg::cfg_t              cfg,
    input  logic                       in_fire,
    input  logic [rcp_pkg::NODE_W-1:0] in_offset,
    input  logic [63:0]                in_unavail,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_entry_valid,
    output logic [rcp_pkg::NODE_W-1:0] out_node,
    output logic [63:0]                out_covered,
    output logic                       out_status,
    output logic [63:0]                out_uncovered,
    output logic                       out_last
);
    import rcp_pkg::*;

    state_t state_reg, state_next;

    logic [63:0]       valid_reg, valid_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [63:0]       keys_reg, keys_next;
    logic [63:0]       avail_reg, avail_next;
    logic [63:0]       base_reg, base_next;
    logic [NODE_W-1:0] offset_reg, offset_next;
    logic [NODE_W-1:0] t_reg, t_next;
    logic [NODE_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]  best_n_reg, best_n_next;
    logic [63:0]       best_cov_reg, best_cov_next;
    logic [63:0]       cov_reg, cov_next;
    logic [63:0]       masked_reg, masked_next;
    logic [CNT_W-1:0]  pass_reg, pass_next;
    logic [63:0]       remain_reg, remain_next;
    logic              ov_reg, ov_next;
    logic              oent_reg, oent_next;
    logic [NODE_W-1:0] onode_reg, onode_next;
    logic [63:0]       ocov_reg, ocov_next;
    logic              olast_reg, olast_next;

    logic              we;
    logic [NODE_W-1:0] raddr;
    logic [63:0]       wdata;
    logic [63:0]       ram_rdata;
    logic [63:0]       rd_cov;
    logic [NODE_W-1:0] v;
    logic [6:0]        n_new;
    logic [63:0]       span_best;
    logic [63:0]       above;

    rcp_ram #(.WIDTH(64), .DEPTH(RING_SIZE)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (best_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Entries not written since the request started read as zero.
    assign rd_cov    = ram_rdata & {64{rd_valid_reg}};
    assign v         = t_reg - offset_reg;
    assign n_new     = pop_count(masked_reg);
    assign span_best = node_span(best_reg, cfg.replica_count);
    assign wdata     = best_cov_reg | (keys_reg & span_best);
    assign above     = valid_reg & ~((64'd2 << t_reg) - 64'd1);
    assign raddr     = (state_reg == S_OSCAN) ? t_reg : v;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_fire) state_next = S_PASS_INIT;
            S_PASS_INIT: state_next = S_ROUND;
            S_ROUND: begin
                if (keys_reg == 64'd0 || avail_reg == 64'd0) state_next = S_PASS_END;
                else state_next = S_RD;
            end
            S_RD: begin
                if (avail_reg[v]) state_next = S_MASK;
                else if (t_reg == NODE_W'(RING_SIZE - 1)) state_next = S_PICK;
            end
            S_MASK: state_next = S_CMP;
            S_CMP: begin
                if (n_new[CNT_W-1:0] == cfg.replica_count
                    || t_reg == NODE_W'(RING_SIZE - 1)) state_next = S_PICK;
                else state_next = S_RD;
            end
            S_PICK: begin
                if (best_n_reg == '0) state_next = S_PASS_END;
                else state_next = S_ROUND;
            end
            S_PASS_END: begin
                if (pass_reg != CNT_W'(1) && keys_reg == 64'd0) state_next = S_PASS_INIT;
                else state_next = S_OSCAN;
            end
            S_OSCAN: begin
                if (valid_reg == 64'd0) state_next = S_OWAIT;
                else if (valid_reg[t_reg]) state_next = S_ODATA;
            end
            S_ODATA: state_next = S_OWAIT;
            S_OWAIT: begin
                if (out_ready) begin
                    if (olast_reg) state_next = S_IDLE;
                    else state_next = S_OSCAN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        valid_next    = valid_reg;
        rd_valid_next = valid_reg[raddr];
        keys_next     = keys_reg;
        avail_next    = avail_reg;
        base_next     = base_reg;
        offset_next   = offset_reg;
        t_next        = t_reg;
        best_next     = best_reg;
        best_n_next   = best_n_reg;
        best_cov_next = best_cov_reg;
        cov_next      = cov_reg;
        masked_next   = masked_reg;
        pass_next     = pass_reg;
        remain_next   = remain_reg;
        ov_next       = ov_reg;
        oent_next     = oent_reg;
        onode_next    = onode_reg;
        ocov_next     = ocov_reg;
        olast_next    = olast_reg;
        we            = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    valid_next  = 64'd0;
                    offset_next = in_offset;
                    base_next   = ~in_unavail & RING_ALL;
                    pass_next   = (cfg.primary_count == '0) ? CNT_W'(1) : cfg.primary_count;
                end
            end
            S_PASS_INIT: begin
                keys_next  = RING_ALL;
                avail_next = base_reg;
            end
            S_ROUND: begin
                t_next      = '0;
                best_next   = '0;
                best_n_next = '0;
            end
            S_RD: begin
                if (!avail_reg[v]) t_next = t_reg + NODE_W'(1);
            end
            S_MASK: begin
                cov_next    = rd_cov;
                masked_next = keys_reg & ~rd_cov & node_span(v, cfg.replica_count);
            end
            S_CMP: begin
                // A full count stops the scan; otherwise the first best wins.
                if (n_new[CNT_W-1:0] == cfg.replica_count
                    || n_new[CNT_W-1:0] > best_n_reg) begin
                    best_next     = v;
                    best_n_next   = n_new[CNT_W-1:0];
                    best_cov_next = cov_reg;
                end
                t_next = t_reg + NODE_W'(1);
            end
            S_PICK: begin
                if (best_n_reg != '0) begin
                    we                   = 1'b1;
                    valid_next[best_reg] = 1'b1;
                    avail_next[best_reg] = 1'b0;
                    keys_next            = keys_reg & ~(span_best & ~best_cov_reg);
                end
            end
            S_PASS_END: begin
                remain_next = keys_reg;
                pass_next   = pass_reg - CNT_W'(1);
                t_next      = '0;
            end
            S_OSCAN: begin
                if (valid_reg == 64'd0) begin
                    ov_next    = 1'b1;
                    oent_next  = 1'b0;
                    onode_next = '0;
                    ocov_next  = 64'd0;
                    olast_next = 1'b1;
                end else if (!valid_reg[t_reg]) begin
                    t_next = t_reg + NODE_W'(1);
                end
            end
            S_ODATA: begin
                ov_next    = 1'b1;
                oent_next  = 1'b1;
                onode_next = t_reg;
                ocov_next  = rd_cov;
                olast_next = (above == 64'd0);
            end
            S_OWAIT: begin
                if (out_ready) begin
                    ov_next = 1'b0;
                    t_next  = t_reg + NODE_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 64'd0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
        end
        rd_valid_reg <= rd_valid_next;
        keys_reg     <= keys_next;
        avail_reg    <= avail_next;
        base_reg     <= base_next;
        offset_reg   <= offset_next;
        t_reg        <= t_next;
        best_reg     <= best_next;
        best_n_reg   <= best_n_next;
        best_cov_reg <= best_cov_next;
        cov_reg      <= cov_next;
        masked_reg   <= masked_next;
        pass_reg     <= pass_next;
        remain_reg   <= remain_next;
        oent_reg     <= oent_next;
        onode_reg    <= onode_next;
        ocov_reg     <= ocov_next;
        olast_reg    <= olast_next;
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = ov_reg;
    assign out_entry_valid = oent_reg;
    assign out_node        = onode_reg;
    assign out_covered     = ocov_reg;
    assign out_status      = (remain_reg != 64'd0);
    assign out_uncovered   = remain_reg;
    assign out_last        = olast_reg;

endmodule

### hw/rtl/ring_coverage_planner.sv
`timescale 1ns / 1ps

// Greedy coverage planner for a 64-node ring.
// s_ channel: one beat per request (start offset, mask of unavailable nodes).
// m_ channel: one beat per node holding coverage, in ascending node order,
// tlast on the final beat; a request with no coverage gives one beat with
// entry_valid low. cfg_ channel writes replica_count (index 0) and
// primary_count (index 1) and is always ready; write it only while idle.
// Operation: each greedy pick scans the candidates through the coverage
// table RAM, stepping past unavailable ones and reading, masking and
// counting each available one, then commits the pick; the scan stops at
// a full count. Passes repeat up to primary_count. Emitting steps through
// the nodes, reading the entry of each reported node. The block takes
// one request at a time; s_tready is low from acceptance until the last
// result beat is taken. When m_tready is low the result beat holds and
// the block waits. Reset returns to idle with no result pending and the
// registers at replica_count 3, primary_count 1; the table needs no clear.
module ring_coverage_planner (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // start_offset[5:0], unavailable_nodes[69:6], zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // node_index[5:0], covered_spaces[69:6],
                                    // uncovered_spaces[133:70], zero fill
    output logic [1:0]   m_tuser,   // entry_valid[0], plan_status[1]
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [rcp_pkg::IDX_W-1:0] cfg_index,
    input  logic [rcp_pkg::CNT_W-1:0] cfg_data
);
    import rcp_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic              entry_valid;
    logic [NODE_W-1:0] node_index;
    logic [63:0]       covered_spaces;
    logic              plan_status;
    logic [63:0]       uncovered_spaces;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_REPLICA_COUNT: cfg_next.replica_count = cfg_data;
                REG_PRIMARY_COUNT: cfg_next.primary_count = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.replica_count <= CNT_W'(3);
            cfg_reg.primary_count <= CNT_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    rcp_engine u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_fire         (s_tvalid && s_tready),
        .in_offset       (s_tdata[5:0]),
        .in_unavail      (s_tdata[69:6]),
        .in_ready        (s_tready),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_entry_valid (entry_valid),
        .out_node        (node_index),
        .out_covered     (covered_spaces),
        .out_status      (plan_status),
        .out_uncovered   (uncovered_spaces),
        .out_last        (m_tlast)
    );

    assign m_tdata = {2'b00, uncovered_spaces, covered_spaces, node_index};
    assign m_tuser = {plan_status, entry_valid};

endmodule

### hw/rtl/rcp_checker.sv
`timescale 1ns / 1ps

module rcp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    // A held result beat stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // One request at a time: no new request while a result is offered.
    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a request was accepted");

    // The empty-plan beat is always the only, and so the last, beat.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty plan beat without tlast");

endmodule

bind ring_coverage_planner rcp_checker u_rcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
